// File: rtl/launch_acceleration_detector_top_assert.svh
// ---------------------------------------------------------------------------
// Launch acceleration detector assertion macros
// Shared property forms for the detector's checker.
// ---------------------------------------------------------------------------
`ifndef LAUNCH_ACCELERATION_DETECTOR_TOP_ASSERT_SVH
`define LAUNCH_ACCELERATION_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LAD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("launch detector check failed");

// next-cycle implication, disabled during reset
`define LAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("launch detector check failed");

`endif

// File: rtl/lad_pkg.sv
// ---------------------------------------------------------------------------
// lad_pkg
// Types and constants shared by the launch acceleration detector files.
// ---------------------------------------------------------------------------
package lad_pkg;

   // field widths
   localparam int ACCEL_W  = 16;
   localparam int STEP_W   = 16;
   localparam int THRESH_W = 15;
   localparam int TIME_W   = 24;
   localparam int PHASE_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // register reset values and limits
   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd7680;
   localparam logic [THRESH_W-1:0] THRESH_MIN   = 15'd256;
   localparam logic [TIME_W-1:0]   TRIG_RESET   = 24'd50000;
   localparam logic [TIME_W-1:0]   MDELAY_RESET = 24'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_TIME     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOTOR_DELAY_TIME = 2'd2;

   // request function codes
   localparam logic FUNC_UPDATE  = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_WAIT     = 2'd0,
      PHASE_SEEN     = 2'd1,
      PHASE_LAUNCHED = 2'd2
   } lad_phase_type;

   typedef struct packed {
      lad_phase_type     phase;
      logic [TIME_W-1:0] above_time;
      logic [TIME_W-1:0] delay_time;
   } lad_state_type;

   typedef struct packed {
      logic [THRESH_W-1:0] accel_threshold;
      logic [TIME_W-1:0]   trigger_time;
      logic [TIME_W-1:0]   motor_delay_time;
   } lad_cfg_type;

endpackage

// File: rtl/lad_req_if.sv
// ---------------------------------------------------------------------------
// lad_req_if
// Request channel: one sample beat or a restart command.
// ---------------------------------------------------------------------------
interface lad_req_if;
   logic                              valid;
   logic                              ready;
   logic                              func;
   logic signed [lad_pkg::ACCEL_W-1:0] accel_sample;
   logic [lad_pkg::STEP_W-1:0]        step_time;

   modport source (output valid, func, accel_sample, step_time, input ready);
   modport sink   (input valid, func, accel_sample, step_time, output ready);
endinterface

// File: rtl/lad_rsp_if.sv
// ---------------------------------------------------------------------------
// lad_rsp_if
// Response channel: phase and launched flag, one beat per request.
// ---------------------------------------------------------------------------
interface lad_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lad_pkg::PHASE_W-1:0] phase;
   logic                        launched;

   modport source (output valid, phase, launched, input ready);
   modport sink   (input valid, phase, launched, output ready);
endinterface

// File: rtl/lad_step.sv
// ---------------------------------------------------------------------------
// lad_step
// Next-state logic of the detector: one threshold compare, saturating adds.
// ---------------------------------------------------------------------------
module lad_step (
   input  lad_pkg::lad_state_type              cur,
   input  lad_pkg::lad_cfg_type                cfg,
   input  logic                                func,
   input  logic signed [lad_pkg::ACCEL_W-1:0]  accel_sample,
   input  logic [lad_pkg::STEP_W-1:0]          step_time,
   output lad_pkg::lad_state_type              nxt,
   output logic                                launched
);

   logic                        above;
   logic [lad_pkg::TIME_W:0]    above_sum;
   logic [lad_pkg::TIME_W:0]    delay_sum;
   logic [lad_pkg::TIME_W-1:0]  above_sat;
   logic [lad_pkg::TIME_W-1:0]  delay_sat;
   logic [lad_pkg::TIME_W-1:0]  step_ext;

   // threshold is positive and below 2^15, fits a signed 16-bit compare
   assign above = accel_sample > $signed({1'b0, cfg.accel_threshold});

   // saturating accumulators
   assign step_ext  = {{(lad_pkg::TIME_W-lad_pkg::STEP_W){1'b0}}, step_time};
   assign above_sum = {1'b0, cur.above_time} + {1'b0, step_ext};
   assign delay_sum = {1'b0, cur.delay_time} + {1'b0, step_ext};
   assign above_sat = above_sum[lad_pkg::TIME_W] ? '1 : above_sum[lad_pkg::TIME_W-1:0];
   assign delay_sat = delay_sum[lad_pkg::TIME_W] ? '1 : delay_sum[lad_pkg::TIME_W-1:0];

   // phase update
   always_comb begin
      nxt = cur;
      if (func == lad_pkg::FUNC_RESTART) begin
         nxt.phase      = lad_pkg::PHASE_WAIT;
         nxt.above_time = '0;
         nxt.delay_time = '0;
      end else begin
         unique case (cur.phase)
            lad_pkg::PHASE_SEEN: begin
               if (above) begin
                  nxt.above_time = above_sat;
                  if (above_sat >= cfg.trigger_time) begin
                     nxt.phase      = lad_pkg::PHASE_LAUNCHED;
                     nxt.delay_time = '0;
                  end
               end else begin
                  nxt.phase      = lad_pkg::PHASE_WAIT;
                  nxt.above_time = '0;
               end
            end
            lad_pkg::PHASE_LAUNCHED: begin
               nxt.delay_time = delay_sat;
            end
            default: begin
               // waiting, and the unused code handled the same way
               nxt.phase = lad_pkg::PHASE_WAIT;
               if (above) begin
                  nxt.phase      = lad_pkg::PHASE_SEEN;
                  nxt.above_time = step_ext;
               end
            end
         endcase
      end
   end

   assign launched = (nxt.phase == lad_pkg::PHASE_LAUNCHED) &&
                     (nxt.delay_time >= cfg.motor_delay_time);

endmodule

// File: rtl/launch_acceleration_detector_top.sv
// ---------------------------------------------------------------------------
// launch_acceleration_detector_top
// Launch detector: threshold timing over acceleration samples, motor delay.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one beat per sample: func (0 update, 1 restart),
//   accel_sample (signed Q8.8 m/s^2) and step_time (us).
//   rsp_chan returns exactly one beat per request: phase (0 waiting,
//   1 acceleration seen, 2 launched) and launched (motor delay elapsed).
//   csr_we/csr_index/csr_wdata write the threshold (index 0, raised to at
//   least 1.0), trigger time (index 1) and motor delay (index 2); write
//   only while no request is in flight. Other indexes are ignored.
// Response timing and throughput:
//   The response is registered and appears in the cycle after the request
//   beat. One beat is taken per cycle while the response is not stalled:
//   compares and saturating adds lie between state and response registers.
// Reset and stall:
//   Synchronous reset returns to waiting, clears both timers, loads the
//   register defaults and drops rsp valid. While the response is stalled
//   req ready stays low; it rises again in the cycle the response is taken.
// ---------------------------------------------------------------------------
module launch_acceleration_detector_top (
   input  logic                               clock,
   input  logic                               reset,
   lad_req_if.sink                            req_chan,
   lad_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [lad_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lad_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lad_pkg::lad_cfg_type        cfg_ff;
   lad_pkg::lad_cfg_type        cfg_in;
   lad_pkg::lad_state_type      state_ff;
   lad_pkg::lad_state_type      state_in;
   logic                        launched_in;
   logic                        rsp_valid_ff;
   logic [lad_pkg::PHASE_W-1:0] rsp_phase_ff;
   logic                        rsp_launched_ff;
   logic [lad_pkg::THRESH_W-1:0] thresh_wr;
   logic                        req_beat;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_beat       = req_chan.valid && req_chan.ready;

   // register writes, threshold clamped to 1.0
   assign thresh_wr = csr_wdata[lad_pkg::THRESH_W-1:0];
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lad_pkg::REG_ACCEL_THRESHOLD:
               cfg_in.accel_threshold = (thresh_wr < lad_pkg::THRESH_MIN) ?
                                        lad_pkg::THRESH_MIN : thresh_wr;
            lad_pkg::REG_TRIGGER_TIME:
               cfg_in.trigger_time = csr_wdata[lad_pkg::TIME_W-1:0];
            lad_pkg::REG_MOTOR_DELAY_TIME:
               cfg_in.motor_delay_time = csr_wdata[lad_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   lad_step u_step (
      .cur          (state_ff),
      .cfg          (cfg_ff),
      .func         (req_chan.func),
      .accel_sample (req_chan.accel_sample),
      .step_time    (req_chan.step_time),
      .nxt          (state_in),
      .launched     (launched_in)
   );

   // config, detector state and response control
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_threshold  <= lad_pkg::THRESH_RESET;
         cfg_ff.trigger_time     <= lad_pkg::TRIG_RESET;
         cfg_ff.motor_delay_time <= lad_pkg::MDELAY_RESET;
         state_ff.phase          <= lad_pkg::PHASE_WAIT;
         state_ff.above_time     <= '0;
         state_ff.delay_time     <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_beat) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_phase_ff    <= state_in.phase;
         rsp_launched_ff <= launched_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.phase    = rsp_phase_ff;
   assign rsp_chan.launched = rsp_launched_ff;

endmodule

// File: rtl/lad_checker.sv
// ---------------------------------------------------------------------------
// lad_checker
// Port-level checks of the launch detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "launch_acceleration_detector_top_assert.svh"

module lad_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_func,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [lad_pkg::PHASE_W-1:0] rsp_phase,
   input logic                        rsp_launched
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // every request beat yields a response beat in the next cycle
   `LAD_ASSERT_NEXT(a_beat_gives_rsp, clock, reset, req_beat, rsp_valid)

   // a restart always answers waiting and not launched
   `LAD_ASSERT_NEXT(a_restart_waits, clock, reset, req_beat && req_func,
                    rsp_valid && rsp_phase == lad_pkg::PHASE_WAIT && !rsp_launched)

   // launched flag only in the launched phase
   `LAD_ASSERT_SAME(a_launched_phase, clock, reset, rsp_valid && rsp_launched,
                    rsp_phase == lad_pkg::PHASE_LAUNCHED)

   // a stalled response keeps its payload
   `LAD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_phase) && $stable(rsp_launched))

endmodule

bind launch_acceleration_detector_top lad_checker u_lad_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_func     (req_chan.func),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_phase    (rsp_chan.phase),
   .rsp_launched (rsp_chan.launched)
);
